[sv/gipl_pkg.sv]
// gipl_pkg: shared types, constants and helpers for the increasing path block
// used by gipl_cell, gipl_linestore and grid_increasing_path_length_top
package gipl_pkg;

   localparam int VAL_W   = 32;
   localparam int LEN_W   = 12;
   localparam int WIDTH_W = 11;
   localparam int ADDR_W  = 3;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [LEN_W-1:0] len_type;

   // one line store entry: value and path length of a cell
   typedef struct packed {
      val_type value;
      len_type length;
   } entry_type;

   localparam len_type NO_PATH     = -12'sd1;
   localparam len_type LEN_ONE     = 12'sd1;
   localparam len_type LEN_MAX     = 12'sd2047;
   localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

   // csr register indexes, taken from paddr bit 2
   localparam logic REG_ROW_WIDTH = 1'b0;

   // length reached through a neighbor, or best if that neighbor does not improve it
   function automatic len_type extend_from(entry_type prev, val_type v, len_type best);
      len_type cand;
      len_type res;
      res = best;
      cand = (prev.length >= LEN_MAX) ? LEN_MAX : len_type'(prev.length + LEN_ONE);
      if (prev.length != NO_PATH && prev.value < v && cand > best) begin
         res = cand;
      end
      return res;
   endfunction

endpackage

[sv/gipl_linestore.sv]
// gipl_linestore: one-row line store holding value and length per column
// depends on gipl_pkg; one write port, one registered read port
module gipl_linestore
   import gipl_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/gipl_cell.sv]
// gipl_cell: path length of one cell from its upper and left neighbors
// depends on gipl_pkg for entry types and extend_from
module gipl_cell
   import gipl_pkg::*;
(
   input  val_type    cell_value,
   input  logic       first_row,
   input  logic       first_col,
   input  entry_type  above,
   input  entry_type  left,
   output len_type    path_length
);

   len_type from_above;
   len_type from_left;

   // best of the two neighbors, top-left corner starts a path of one cell
   always_comb begin
      from_above = first_row ? NO_PATH : extend_from(above, cell_value, NO_PATH);
      from_left  = first_col ? from_above : extend_from(left, cell_value, from_above);
      if (first_row && first_col) begin
         path_length = LEN_ONE;
      end else begin
         path_length = from_left;
      end
   end

endmodule

[sv/grid_increasing_path_length_top.sv]
// Longest strictly increasing right/down path through a matrix streamed in
// raster order. Takes one cell per clock with no gaps while no last cell
// waits on rsp_tready; the last cell's result passes through the stage one
// register and the result register. The previous row lives in a
// MAX_COLUMNS-entry line store with one write and one registered read port,
// read as each cell is accepted; when the cell above is the one just
// computed (row width 1) it is forwarded. The store needs no clearing pass:
// every row after the first reads only entries written by the row before.
// row_width at csr address 0 sets cells per row (0 acts as 1, above
// MAX_COLUMNS acts as MAX_COLUMNS). The user writes row_width only while
// the block is idle; the block itself does not enforce this.
// depends on gipl_pkg, gipl_linestore, gipl_cell
module grid_increasing_path_length_top
   import gipl_pkg::*;
#(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   // input stream
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // [31:0] cell_value
   input  logic               req_tlast,   // last_cell
   // result stream
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,   // [11:0] path_length, [15:12] zero
   // csr port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
   localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLUMNS);
   localparam logic [CMP_W-1:0] ONE_C      = CMP_W'(1);

   // csr
   logic [WIDTH_W-1:0] row_width_ff;
   logic               csr_write;

   // raster position of the next cell
   logic [COL_W-1:0]   col_ff, col_in;
   logic               first_row_ff, first_row_in;

   // stage one: accepted cell
   logic               s1_valid_ff;
   val_type            s1_value_ff;
   logic               s1_last_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic               s1_first_row_ff;

   // forwarding of the cell above when it was computed in the accept cycle
   logic               byp_ff;
   entry_type          byp_data_ff;

   // left neighbor
   entry_type          left_ff;

   // result register
   logic               out_valid_ff;
   len_type            out_len_ff;

   logic               accept;
   logic               s1_adv;
   logic [CMP_W-1:0]   eff_width;
   logic [CMP_W-1:0]   width_ext;
   logic               wrap;
   entry_type          above_mem;
   entry_type          above;
   entry_type          cur_entry;
   len_type            cur_len;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ROW_WIDTH) ? 32'(row_width_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
      end else if (csr_write && csr_paddr[2] == REG_ROW_WIDTH) begin
         row_width_ff <= csr_pwdata[WIDTH_W-1:0];
      end
   end

   // handshake
   assign s1_adv     = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   // next raster position
   always_comb begin
      width_ext = CMP_W'(row_width_ff);
      if (width_ext == '0) begin
         eff_width = ONE_C;
      end else if (width_ext > MAX_COLS_C) begin
         eff_width = MAX_COLS_C;
      end else begin
         eff_width = width_ext;
      end
      wrap = (CMP_W'(col_ff) + ONE_C) >= eff_width;
      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (req_tlast) begin
         col_in       = '0;
         first_row_in = 1'b1;
      end else if (wrap) begin
         col_in       = '0;
         first_row_in = 1'b0;
      end else begin
         col_in = col_ff + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
      end else if (accept) begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
      end
   end

   // stage one register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff     <= val_type'(req_tdata);
         s1_last_ff      <= req_tlast;
         s1_col_ff       <= col_ff;
         s1_first_row_ff <= first_row_ff;
         byp_ff          <= s1_adv && (s1_col_ff == col_ff);
         byp_data_ff     <= cur_entry;
      end
   end

   // line store
   gipl_linestore #(
      .DEPTH (MAX_COLUMNS),
      .AW    (COL_W)
   ) u_linestore (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (cur_entry),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above_mem)
   );

   assign above = byp_ff ? byp_data_ff : above_mem;

   // cell length
   gipl_cell u_cell (
      .cell_value  (s1_value_ff),
      .first_row   (s1_first_row_ff),
      .first_col   (s1_col_ff == '0),
      .above       (above),
      .left        (left_ff),
      .path_length (cur_len)
   );

   assign cur_entry.value  = s1_value_ff;
   assign cur_entry.length = cur_len;

   // left neighbor, cleared at the end of a matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (s1_adv) begin
         left_ff <= s1_last_ff ? '0 : cur_entry;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv && s1_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         out_len_ff <= cur_len;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_len_ff};

endmodule
